/* sv/amgs_pkg.sv */
// Shared constants, handshake codes and control types for the graph store.
package amgs_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VTX_W        = 5;
  localparam int ACT_W        = 3;
  localparam int VCNT_W       = 6;
  localparam int CNT_W        = 11;

  // Rows and columns reachable through the vertex fields
  localparam int NUM_ROWS = (MAX_VERTICES < (1 << VTX_W)) ? MAX_VERTICES : (1 << VTX_W);
  localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int GRP_N    = (NUM_ROWS + 7) / 8;

  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TEST   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEGREE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIST   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TOTAL  = 3'd5;

  typedef enum logic [1:0] {
    RES_SINGLE = 2'd0,
    RES_NEIGH  = 2'd1,
    RES_NONE   = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     col_adv;
    logic     row_acc;
    logic     use_row_cnt;
    logic     load_out;
    res_sel_t sel;
    logic     last;
  } amgs_cmd_t;

  typedef struct packed {
    logic list_cur;
    logic list_rem;
    logic scan_end;
    logic slot_free;
  } amgs_stat_t;

  // Count set bits of one row: byte-wide partial counts, then a short sum
  function automatic logic [CNT_W-1:0] popcount(input logic [NUM_ROWS-1:0] v);
    logic [CNT_W-1:0] total;
    logic [3:0]       part;
    int               idx;
    total = '0;
    for (int g = 0; g < GRP_N; g++) begin
      part = '0;
      for (int k = 0; k < 8; k++) begin
        idx = g * 8 + k;
        if (idx < NUM_ROWS) part = part + 4'(v[idx]);
      end
      total = total + CNT_W'(part);
    end
    return total;
  endfunction

endpackage

/* sv/adjacency_matrix_graph_store.sv */
// Results: add, remove, test, degree and spare codes give one result each; the edge total
// sums rows 0 to min(vertex_count, 32) - 1; a listing gives one result per neighbour, or one none-found result.
// Throughput: one transaction at a time; the next is taken once the last result is
// in the output register, which holds it while the next transaction is accepted.
// Reset: synchronous rst_n clears the whole matrix and vertex_count.
module adjacency_matrix_graph_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [amgs_pkg::VCNT_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [amgs_pkg::ACT_W-1:0]    in_action,
  input  logic [amgs_pkg::VTX_W-1:0]    in_from_vertex,
  input  logic [amgs_pkg::VTX_W-1:0]    in_to_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_edge_present,
  output logic [amgs_pkg::CNT_W-1:0]    out_count,
  output logic [amgs_pkg::VTX_W-1:0]    out_neighbour,
  output logic                          out_none_found,
  output logic                          out_last
);

  amgs_pkg::amgs_cmd_t  cmd;
  amgs_pkg::amgs_stat_t stat;

  amgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  amgs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_action        (in_action),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_edge_present (out_edge_present),
    .out_count        (out_count),
    .out_neighbour    (out_neighbour),
    .out_none_found   (out_none_found),
    .out_last         (out_last)
  );

endmodule

/* sv/amgs_ctrl.sv */
// Controller state machine: sequences edge updates, row scans and result issue.
module amgs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [amgs_pkg::ACT_W-1:0]    in_action,
  output logic                          in_ready,
  input  amgs_pkg::amgs_stat_t          stat,
  output amgs_pkg::amgs_cmd_t           cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LIST  = 4'b0010,
    S_TOTAL = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.sel         = amgs_pkg::RES_SINGLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_action == amgs_pkg::ACT_LIST)       state_nxt = S_LIST;
          else if (in_action == amgs_pkg::ACT_TOTAL) state_nxt = S_TOTAL;
          else                                       state_nxt = S_EMIT;
        end
      end
      S_LIST: begin
        if (stat.list_cur) begin
          if (stat.slot_free) begin
            cmd.load_out = 1'b1;
            cmd.sel      = amgs_pkg::RES_NEIGH;
            cmd.last     = !stat.list_rem;
            if (stat.list_rem) cmd.col_adv = 1'b1;
            else               state_nxt   = S_IDLE;
          end
        end else if (stat.list_rem) begin
          cmd.col_adv = 1'b1;
        end else if (stat.slot_free) begin
          // nothing set in the row at all
          cmd.load_out = 1'b1;
          cmd.sel      = amgs_pkg::RES_NONE;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_TOTAL: begin
        cmd.use_row_cnt = 1'b1;
        if (stat.scan_end) state_nxt   = S_EMIT;
        else               cmd.row_acc = 1'b1;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.slot_free)
    else $error("result issued while output register is occupied");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start work");

endmodule

/* sv/amgs_dp.sv */
// Datapath: adjacency matrix, scan counters, row popcount and output register.
module amgs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [amgs_pkg::VCNT_W-1:0]   cfg_wr_data,
  input  logic [amgs_pkg::ACT_W-1:0]    in_action,
  input  logic [amgs_pkg::VTX_W-1:0]    in_from_vertex,
  input  logic [amgs_pkg::VTX_W-1:0]    in_to_vertex,
  input  amgs_pkg::amgs_cmd_t           cmd,
  output amgs_pkg::amgs_stat_t          stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_edge_present,
  output logic [amgs_pkg::CNT_W-1:0]    out_count,
  output logic [amgs_pkg::VTX_W-1:0]    out_neighbour,
  output logic                          out_none_found,
  output logic                          out_last
);

  localparam int NR = amgs_pkg::NUM_ROWS;
  localparam int AW = amgs_pkg::ROW_AW;

  logic [NR-1:0]                  rows_r [NR];
  logic [amgs_pkg::VCNT_W-1:0]    vcnt_r;
  logic [amgs_pkg::ACT_W-1:0]     act_r;
  logic [amgs_pkg::VTX_W-1:0]     src_r, dst_r;
  logic [AW-1:0]                  col_r;
  logic [amgs_pkg::VCNT_W-1:0]    rc_r;
  logic [amgs_pkg::CNT_W-1:0]     acc_r;

  logic                           out_valid_r, out_present_r, out_none_r, out_last_r;
  logic [amgs_pkg::CNT_W-1:0]     out_count_r;
  logic [amgs_pkg::VTX_W-1:0]     out_nb_r;

  logic                           src_ok, dst_ok, row_ok;
  logic [amgs_pkg::VCNT_W-1:0]    lim;
  logic [AW-1:0]                  rd_addr;
  logic [NR-1:0]                  row_eff, lim_mask, above, mrow;
  logic [amgs_pkg::CNT_W-1:0]     row_pop;
  logic                           single_present;
  logic [amgs_pkg::CNT_W-1:0]     single_count;
  logic                           wr_edge;

  always_comb begin
    src_ok  = amgs_pkg::VCNT_W'(src_r) < amgs_pkg::VCNT_W'(NR);
    dst_ok  = amgs_pkg::VCNT_W'(dst_r) < amgs_pkg::VCNT_W'(NR);
    lim     = (vcnt_r < amgs_pkg::VCNT_W'(NR)) ? vcnt_r : amgs_pkg::VCNT_W'(NR);
    rd_addr = cmd.use_row_cnt ? rc_r[AW-1:0] : src_r[AW-1:0];
    row_ok  = cmd.use_row_cnt || src_ok;
    row_eff = row_ok ? rows_r[rd_addr] : '0;
    for (int j = 0; j < NR; j++) begin
      lim_mask[j] = amgs_pkg::VCNT_W'(j) < lim;
      above[j]    = AW'(j) > col_r;
    end
    mrow    = row_eff & lim_mask;
    row_pop = amgs_pkg::popcount(mrow);

    stat.list_cur  = mrow[col_r];
    stat.list_rem  = |(mrow & above);
    stat.scan_end  = (rc_r >= lim);
    stat.slot_free = !out_valid_r || out_ready;

    single_present = (act_r == amgs_pkg::ACT_TEST) && dst_ok && row_eff[dst_r[AW-1:0]];
    case (act_r)
      amgs_pkg::ACT_DEGREE: single_count = row_pop;
      amgs_pkg::ACT_TOTAL:  single_count = acc_r;
      default:              single_count = '0;
    endcase

    wr_edge = cmd.load_out && (cmd.sel == amgs_pkg::RES_SINGLE) && src_ok && dst_ok &&
              ((act_r == amgs_pkg::ACT_ADD) || (act_r == amgs_pkg::ACT_REMOVE));
  end

  // Control state and the matrix, which starts empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      rc_r        <= '0;
      acc_r       <= '0;
      for (int i = 0; i < NR; i++) rows_r[i] <= '0;
    end else begin
      if (cfg_wr_en) vcnt_r <= cfg_wr_data;
      if (cmd.capture) begin
        col_r <= '0;
        rc_r  <= '0;
        acc_r <= '0;
      end else begin
        if (cmd.col_adv) col_r <= col_r + AW'(1);
        if (cmd.row_acc) begin
          acc_r <= acc_r + row_pop;
          rc_r  <= rc_r + amgs_pkg::VCNT_W'(1);
        end
      end
      if (wr_edge) rows_r[src_r[AW-1:0]][dst_r[AW-1:0]] <= (act_r == amgs_pkg::ACT_ADD);
      if (cmd.load_out)   out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload: request fields and the result held for the output side
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      src_r <= in_from_vertex;
      dst_r <= in_to_vertex;
    end
    if (cmd.load_out) begin
      out_last_r <= cmd.last;
      case (cmd.sel)
        amgs_pkg::RES_NEIGH: begin
          out_present_r <= 1'b0;
          out_count_r   <= '0;
          out_nb_r      <= amgs_pkg::VTX_W'(col_r);
          out_none_r    <= 1'b0;
        end
        amgs_pkg::RES_NONE: begin
          out_present_r <= 1'b0;
          out_count_r   <= '0;
          out_nb_r      <= '0;
          out_none_r    <= 1'b1;
        end
        default: begin
          out_present_r <= single_present;
          out_count_r   <= single_count;
          out_nb_r      <= '0;
          out_none_r    <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_edge_present = out_present_r;
  assign out_count        = out_count_r;
  assign out_neighbour    = out_nb_r;
  assign out_none_found   = out_none_r;
  assign out_last         = out_last_r;

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= amgs_pkg::CNT_W'(NR * NR))
    else $error("edge total exceeds matrix size");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_none_r) |-> out_last_r)
    else $error("empty listing result not marked last");

endmodule

/* bench/adjacency_matrix_graph_store_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the adjacency matrix graph store: random handshakes, shadow matrix.
module adjacency_matrix_graph_store_test;

  // Codes the block treats as no-ops
  localparam logic [amgs_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [amgs_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic [amgs_pkg::ACT_W-1:0] action;
    logic [amgs_pkg::VTX_W-1:0] src_vertex;
    logic [amgs_pkg::VTX_W-1:0] dst_vertex;
  } graph_request_t;

  typedef struct packed {
    logic                       edge_present;
    logic [amgs_pkg::CNT_W-1:0] count;
    logic [amgs_pkg::VTX_W-1:0] neighbour;
    logic                       none_found;
    logic                       last;
  } graph_result_t;

  logic                        clk              = 1'b0;
  logic                        rst_n            = 1'b0;
  logic                        cfg_wr_en        = 1'b0;
  logic [amgs_pkg::VCNT_W-1:0] cfg_wr_data      = '0;
  logic                        in_valid         = 1'b0;
  logic                        in_ready;
  logic [amgs_pkg::ACT_W-1:0]  in_action        = '0;
  logic [amgs_pkg::VTX_W-1:0]  in_from_vertex   = '0;
  logic [amgs_pkg::VTX_W-1:0]  in_to_vertex     = '0;
  logic                        out_valid;
  logic                        out_ready        = 1'b0;
  logic                        out_edge_present;
  logic [amgs_pkg::CNT_W-1:0]  out_count;
  logic [amgs_pkg::VTX_W-1:0]  out_neighbour;
  logic                        out_none_found;
  logic                        out_last;

  adjacency_matrix_graph_store dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_edge_present (out_edge_present),
    .out_count        (out_count),
    .out_neighbour    (out_neighbour),
    .out_none_found   (out_none_found),
    .out_last         (out_last)
  );

  graph_request_t              pending_requests[$];
  graph_result_t               expected_results[$];
  logic [amgs_pkg::NUM_ROWS-1:0] shadow_rows [amgs_pkg::NUM_ROWS];
  logic [amgs_pkg::VCNT_W-1:0] shadow_vertex_count = '0;
  int                          error_count   = 0;
  int                          send_idle_pct = 17;
  int                          recv_idle_pct = 66;
  int                          hold_requests = 0;
  int                          holds_served;
  int                          hold_left;
  int                          cycle_count   = 0;
  int                          recent_row    = 0;
  int                          recent_cols[$];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit edge_stored(input int row, input int col);
    if (row >= amgs_pkg::NUM_ROWS || col >= amgs_pkg::NUM_ROWS) return 1'b0;
    return shadow_rows[row][col];
  endfunction

  function automatic int row_degree(input int row, input int lim);
    int deg;
    deg = 0;
    for (int j = 0; j < lim; j++)
      if (edge_stored(row, j)) deg++;
    return deg;
  endfunction

  function automatic void expect_result(input graph_result_t res);
    expected_results.insert(expected_results.size(), res);
  endfunction

  // Apply one transaction to the shadow matrix and queue the results it causes
  function automatic void predict_request(input graph_request_t req);
    graph_result_t res;
    graph_result_t held;
    bit            have_held;
    int            lim;
    int            total;
    lim = shadow_vertex_count;
    if (lim > amgs_pkg::NUM_ROWS) lim = amgs_pkg::NUM_ROWS;
    res = '0;
    res.last = 1'b1;
    have_held = 1'b0;
    held = '0;
    case (req.action)
      amgs_pkg::ACT_ADD: begin
        if (req.src_vertex < amgs_pkg::NUM_ROWS && req.dst_vertex < amgs_pkg::NUM_ROWS)
          shadow_rows[req.src_vertex][req.dst_vertex] = 1'b1;
        expect_result(res);
      end
      amgs_pkg::ACT_REMOVE: begin
        if (req.src_vertex < amgs_pkg::NUM_ROWS && req.dst_vertex < amgs_pkg::NUM_ROWS)
          shadow_rows[req.src_vertex][req.dst_vertex] = 1'b0;
        expect_result(res);
      end
      amgs_pkg::ACT_TEST: begin
        res.edge_present = edge_stored(req.src_vertex, req.dst_vertex);
        expect_result(res);
      end
      amgs_pkg::ACT_DEGREE: begin
        res.count = amgs_pkg::CNT_W'(row_degree(req.src_vertex, lim));
        expect_result(res);
      end
      amgs_pkg::ACT_LIST: begin
        // Hold each neighbour back one step so the final one can be marked last
        for (int j = 0; j < lim; j++) begin
          if (edge_stored(req.src_vertex, j)) begin
            if (have_held) expect_result(held);
            held = '0;
            held.neighbour = amgs_pkg::VTX_W'(j);
            have_held = 1'b1;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          expect_result(held);
        end else begin
          res.none_found = 1'b1;
          expect_result(res);
        end
      end
      amgs_pkg::ACT_TOTAL: begin
        total = 0;
        for (int i = 0; i < lim; i++) total += row_degree(i, lim);
        res.count = amgs_pkg::CNT_W'(total);
        expect_result(res);
      end
      default: expect_result(res);
    endcase
  endfunction

  task automatic push_request(input logic [amgs_pkg::ACT_W-1:0] act, input int src,
                              input int dst);
    graph_request_t req;
    req.action     = act;
    req.src_vertex = amgs_pkg::VTX_W'(src);
    req.dst_vertex = amgs_pkg::VTX_W'(dst);
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Sample at the falling edge so the driver's updates of this cycle are settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [amgs_pkg::VCNT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    shadow_vertex_count = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly build-then-query sequences on one row, with some noise mixed in
  task automatic queue_random_requests(input int n_items, input bit full_row_first);
    int start_size;
    int kind;
    int row;
    int k;
    int col;
    start_size = pending_requests.size();
    while (pending_requests.size() - start_size < n_items) begin
      kind = $urandom_range(0, 9);
      if (full_row_first && pending_requests.size() == start_size) kind = 10;
      row = $urandom_range(0, amgs_pkg::NUM_ROWS - 1);
      case (kind)
        0, 1, 2: begin
          push_request(amgs_pkg::ACT_W'($urandom_range(0, 7)), $urandom_range(0, 31),
                       $urandom_range(0, 31));
        end
        3, 4, 5, 6: begin
          recent_row = row;
          recent_cols.delete();
          k = $urandom_range(1, 6);
          for (int n = 0; n < k; n++) begin
            col = $urandom_range(0, amgs_pkg::NUM_ROWS - 1);
            recent_cols.insert(recent_cols.size(), col);
            push_request(amgs_pkg::ACT_ADD, row, col);
          end
          push_request(amgs_pkg::ACT_TEST, row, recent_cols[$urandom_range(0, k - 1)]);
          push_request(amgs_pkg::ACT_TEST, row, $urandom_range(0, 31));
          push_request(amgs_pkg::ACT_DEGREE, row, $urandom_range(0, 31));
          push_request(amgs_pkg::ACT_LIST, row, $urandom_range(0, 31));
        end
        7: begin
          foreach (recent_cols[n])
            if ($urandom_range(0, 1))
              push_request(amgs_pkg::ACT_REMOVE, recent_row, recent_cols[n]);
          push_request(amgs_pkg::ACT_REMOVE, recent_row, $urandom_range(0, 31));
          push_request(amgs_pkg::ACT_LIST, recent_row, $urandom_range(0, 31));
          push_request(amgs_pkg::ACT_TEST, recent_row,
                       recent_cols.size() ? recent_cols[0] : 0);
        end
        8: begin
          push_request(amgs_pkg::ACT_TOTAL, $urandom_range(0, 31), $urandom_range(0, 31));
          push_request(amgs_pkg::ACT_DEGREE, row, $urandom_range(0, 31));
        end
        9: begin
          push_request(amgs_pkg::ACT_LIST, row, $urandom_range(0, 31));
          push_request(amgs_pkg::ACT_TEST, row, $urandom_range(0, 31));
        end
        default: begin
          // Fill one row completely so the listing gives a result per vertex
          for (int j = 0; j < amgs_pkg::NUM_ROWS; j++)
            push_request(amgs_pkg::ACT_ADD, row, j);
          push_request(amgs_pkg::ACT_LIST, row, $urandom_range(0, 31));
          push_request(amgs_pkg::ACT_DEGREE, row, $urandom_range(0, 31));
          push_request(amgs_pkg::ACT_TOTAL, row, $urandom_range(0, 31));
        end
      endcase
    end
  endtask

  task automatic random_phase(input logic [amgs_pkg::VCNT_W-1:0] vc, input int n_items,
                              input bit pause_midway, input bit full_row_first);
    wait_drained();
    write_vertex_count(vc);
    if (pause_midway) begin
      queue_random_requests(n_items / 2, full_row_first);
      // Hold the sender until every result so far has come back
      wait_drained();
      queue_random_requests(n_items - n_items / 2, 1'b0);
    end else begin
      queue_random_requests(n_items, full_row_first);
    end
  endtask

  // Driver: advance to the next pending transaction once the current one is taken
  always @(posedge clk) begin : drive_requests
    graph_request_t next_req;
    graph_request_t taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.action     = in_action;
        taken.src_vertex = in_from_vertex;
        taken.dst_vertex = in_to_vertex;
        predict_request(taken);
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid       <= 1'b1;
          in_action      <= next_req.action;
          in_from_vertex <= next_req.src_vertex;
          in_to_vertex   <= next_req.dst_vertex;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    graph_result_t want;
    if (!rst_n) begin
      out_ready    <= 1'b0;
      hold_left    = 0;
      holds_served = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual present=%0d count=%0d",
                   $time, out_edge_present, out_count);
          $display("%0t:   nb=%0d none=%0d last=%0d",
                   $time, out_neighbour, out_none_found, out_last);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("edge_present", want.edge_present, out_edge_present);
          check_field("count", want.count, out_count);
          check_field("neighbour", want.neighbour, out_neighbour);
          check_field("none_found", want.none_found, out_none_found);
          check_field("last", want.last, out_last);
        end
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("adjacency_matrix_graph_store: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < amgs_pkg::NUM_ROWS; i++) shadow_rows[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners of the matrix, duplicates, absent edges, spare codes
    write_vertex_count(6'd32);
    push_request(amgs_pkg::ACT_TOTAL, 0, 0);
    push_request(amgs_pkg::ACT_LIST, 0, 0);
    push_request(amgs_pkg::ACT_ADD, 0, 0);
    push_request(amgs_pkg::ACT_ADD, 0, 31);
    push_request(amgs_pkg::ACT_ADD, 31, 0);
    push_request(amgs_pkg::ACT_ADD, 31, 31);
    push_request(amgs_pkg::ACT_ADD, 5, 17);
    push_request(amgs_pkg::ACT_ADD, 5, 3);
    push_request(amgs_pkg::ACT_ADD, 0, 0);
    push_request(amgs_pkg::ACT_TEST, 0, 31);
    push_request(amgs_pkg::ACT_TEST, 31, 31);
    push_request(amgs_pkg::ACT_TEST, 1, 1);
    push_request(amgs_pkg::ACT_DEGREE, 0, 31);
    push_request(amgs_pkg::ACT_DEGREE, 31, 0);
    push_request(amgs_pkg::ACT_LIST, 5, 0);
    push_request(amgs_pkg::ACT_LIST, 31, 31);
    push_request(amgs_pkg::ACT_TOTAL, 31, 31);
    push_request(amgs_pkg::ACT_REMOVE, 5, 3);
    push_request(amgs_pkg::ACT_REMOVE, 7, 7);
    push_request(amgs_pkg::ACT_TEST, 5, 3);
    push_request(amgs_pkg::ACT_LIST, 5, 31);
    push_request(ACT_SPARE_LO, 31, 31);
    push_request(ACT_SPARE_HI, 0, 0);
    push_request(amgs_pkg::ACT_DEGREE, 12, 12);

    // No vertices in use: every count is zero and every listing empty
    wait_drained();
    write_vertex_count(6'd0);
    push_request(amgs_pkg::ACT_DEGREE, 0, 0);
    push_request(amgs_pkg::ACT_LIST, 31, 0);
    push_request(amgs_pkg::ACT_TOTAL, 0, 0);

    // Sender idles lightly, receiver heavily; one long receiver hold-off
    random_phase(6'd63, 20, 1'b0, 1'b0);
    hold_requests++;
    random_phase(6'd1, 10, 1'b0, 1'b0);

    send_idle_pct = 66;
    recv_idle_pct = 17;
    random_phase(amgs_pkg::VCNT_W'($urandom_range(0, 63)), 20, 1'b1, 1'b0);
    random_phase(6'd32, 15, 1'b0, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(amgs_pkg::VCNT_W'($urandom_range(2, 31)), 20, 1'b0, 1'b0);
    random_phase(6'd32, 35, 1'b0, 1'b1);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("adjacency_matrix_graph_store: match");
    end else begin
      $display("adjacency_matrix_graph_store: mismatch");
    end
    $finish;
  end

endmodule
